// ===== rtl/core/assert_macros.svh =====
// Assertion helpers shared by the core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked at every rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

// ===== rtl/core/bmmd_pkg.sv =====
// ----------------------------------------------------------------------------
// bmmd_pkg
// Types, constants and the boot ROM table of the banked memory map decoder.
// ----------------------------------------------------------------------------
package bmmd_pkg;
  localparam int WORK_RAM_BYTES = 32768;
  localparam int HIGH_RAM_BYTES = 256;
  localparam int RANGE_SLOTS    = 6;
  localparam int BOOT_ROM_BYTES = 256;
  localparam int WRAM_AW        = $clog2(WORK_RAM_BYTES);

  localparam logic [1:0] FUNC_READ  = 2'd0;
  localparam logic [1:0] FUNC_WRITE = 2'd1;
  localparam logic [1:0] FUNC_RAISE = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_RESTR   = 2'd1;
  localparam logic [1:0] ST_UNKNOWN = 2'd2;

  localparam logic [2:0] CFG_MODE   = 3'd0;
  localparam logic [2:0] CFG_COUNT  = 3'd1;

  localparam logic [15:0] REG_IF       = 16'hFF0F;
  localparam logic [15:0] REG_SPEED    = 16'hFF4D;
  localparam logic [15:0] REG_BOOT_OFF = 16'hFF50;
  localparam logic [15:0] REG_BANK     = 16'hFF70;

  typedef enum logic [2:0] {
    S_IDLE, S_LOOK, S_RMW, S_OUT
  } state_t;

  // Controller commands and datapath status.
  typedef struct packed {
    logic load;    // capture request
    logic exec;    // decode and perform access, memory read issued
    logic rmw;     // second half of a raise: write IF back
  } cmd_t;

  typedef struct packed {
    logic is_raise;
    logic out_taken;
  } stat_t;

  localparam logic [7:0] BOOT_ROM [256] = '{
    8'h31,8'hFE,8'hFF,8'hAF,8'h21,8'hFF,8'h9F,8'h32,8'hCB,8'h7C,8'h20,8'hFB,8'h21,8'h26,8'hFF,8'h0E,
    8'h11,8'h3E,8'h80,8'h32,8'hE2,8'h0C,8'h3E,8'hF3,8'hE2,8'h32,8'h3E,8'h77,8'h77,8'h3E,8'hFC,8'hE0,
    8'h47,8'h11,8'h04,8'h01,8'h21,8'h10,8'h80,8'h1A,8'hCD,8'h95,8'h00,8'hCD,8'h96,8'h00,8'h13,8'h7B,
    8'hFE,8'h34,8'h20,8'hF3,8'h11,8'hD8,8'h00,8'h06,8'h08,8'h1A,8'h13,8'h22,8'h23,8'h05,8'h20,8'hF9,
    8'h3E,8'h19,8'hEA,8'h10,8'h99,8'h21,8'h2F,8'h99,8'h0E,8'h0C,8'h3D,8'h28,8'h08,8'h32,8'h0D,8'h20,
    8'hF9,8'h2E,8'h0F,8'h18,8'hF3,8'h67,8'h3E,8'h64,8'h57,8'hE0,8'h42,8'h3E,8'h91,8'hE0,8'h40,8'h04,
    8'h1E,8'h02,8'h0E,8'h0C,8'hF0,8'h44,8'hFE,8'h90,8'h20,8'hFA,8'h0D,8'h20,8'hF7,8'h1D,8'h20,8'hF2,
    8'h0E,8'h13,8'h24,8'h7C,8'h1E,8'h83,8'hFE,8'h62,8'h28,8'h06,8'h1E,8'hC1,8'hFE,8'h64,8'h20,8'h06,
    8'h7B,8'hE2,8'h0C,8'h3E,8'h87,8'hE2,8'hF0,8'h42,8'h90,8'hE0,8'h42,8'h15,8'h20,8'hD2,8'h05,8'h20,
    8'h4F,8'h16,8'h20,8'h18,8'hCB,8'h4F,8'h06,8'h04,8'hC5,8'hCB,8'h11,8'h17,8'hC1,8'hCB,8'h11,8'h17,
    8'h05,8'h20,8'hF5,8'h22,8'h23,8'h22,8'h23,8'hC9,8'hCE,8'hED,8'h66,8'h66,8'hCC,8'h0D,8'h00,8'h0B,
    8'h03,8'h73,8'h00,8'h83,8'h00,8'h0C,8'h00,8'h0D,8'h00,8'h08,8'h11,8'h1F,8'h88,8'h89,8'h00,8'h0E,
    8'hDC,8'hCC,8'h6E,8'hE6,8'hDD,8'hDD,8'hD9,8'h99,8'hBB,8'hBB,8'h67,8'h63,8'h6E,8'h0E,8'hEC,8'hCC,
    8'hDD,8'hDC,8'h99,8'h9F,8'hBB,8'hB9,8'h33,8'h3E,8'h3C,8'h42,8'hB9,8'hA5,8'hB9,8'hA5,8'h42,8'h3C,
    8'h21,8'h04,8'h01,8'h11,8'hA8,8'h00,8'h1A,8'h13,8'hBE,8'h20,8'hFE,8'h23,8'h7D,8'hFE,8'h34,8'h20,
    8'hF5,8'h06,8'h19,8'h78,8'h86,8'h23,8'h05,8'h20,8'hFB,8'h86,8'h20,8'hFE,8'h3E,8'h01,8'hE0,8'h50
  };

  // Reset value of a high RAM byte.
  function automatic logic [7:0] hram_reset(input logic [7:0] a);
    logic [7:0] v;
    v = (a <= 8'h7E) ? 8'hFF : 8'h00;
    if (a == REG_IF[7:0])    v = 8'hE1;
    if (a == REG_SPEED[7:0]) v = 8'h00;
    return v;
  endfunction
endpackage

// ===== rtl/core/bmmd_ctrl.sv =====
// ----------------------------------------------------------------------------
// bmmd_ctrl
// Sequencer: capture, decode and memory access, optional write-back, result.
// ----------------------------------------------------------------------------
module bmmd_ctrl import bmmd_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   in_tvalid,
  output logic   in_tready,
  output logic   out_tvalid,
  input  stat_t  stat,
  output cmd_t   cmd
);
  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (in_tvalid) state_nxt = S_LOOK;
      S_LOOK: state_nxt = stat.is_raise ? S_RMW : S_OUT;
      S_RMW:  state_nxt = S_OUT;
      S_OUT: begin
        if (stat.out_taken) state_nxt = in_tvalid ? S_LOOK : S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd        = '0;
    in_tready  = 1'b0;
    out_tvalid = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        cmd.load  = in_tvalid;
      end
      S_LOOK: cmd.exec = 1'b1;
      S_RMW:  cmd.rmw  = 1'b1;
      S_OUT: begin
        out_tvalid = 1'b1;
        in_tready  = stat.out_taken;
        cmd.load   = stat.out_taken && in_tvalid;
      end
      default: ;
    endcase
  end
endmodule

// ===== rtl/core/bmmd_datapath.sv =====
// ----------------------------------------------------------------------------
// bmmd_datapath
// Address decode, forwarding range match, work RAM, high RAM and registers.
// ----------------------------------------------------------------------------
module bmmd_datapath import bmmd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  cmd_t        cmd,
  output stat_t       stat,
  input  logic        out_tready,
  input  logic [1:0]  in_func,
  input  logic [15:0] in_address,
  input  logic [7:0]  in_write_data,
  input  logic [2:0]  in_interrupt_bit,
  input  logic        cfg_valid,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output logic [7:0]  read_data,
  output logic        forwarded,
  output logic [2:0]  forward_slot,
  output logic [1:0]  status
);
  logic [2:0]  mode_r;
  logic [2:0]  count_r;
  logic [31:0] range_r [RANGE_SLOTS];
  logic        boot_r;
  logic [2:0]  bank_r;
  logic [7:0]  hram_r [HIGH_RAM_BYTES];
  logic [HIGH_RAM_BYTES-1:0] hvalid_r;
  logic [7:0]  wram [WORK_RAM_BYTES];

  logic [1:0]  func_r;
  logic [15:0] addr_r;
  logic [7:0]  wd_r;
  logic [2:0]  bit_r;
  // Result of the decode, registered.
  logic [7:0]  rdat_r;
  logic        fwd_r;
  logic [2:0]  slot_r;
  logic [1:0]  st_r;
  logic        wsel_r;   // result comes from work RAM read
  logic [7:0]  wq_r;
  logic [7:0]  ifv_r;    // IF value read for a raise
  // High RAM byte of the request, read as the request is captured.
  logic [7:0]  hq_r;
  logic [7:0]  hkey;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= '0;
      count_r <= '0;
      for (int i = 0; i < RANGE_SLOTS; i++) range_r[i] <= '0;
    end else if (cfg_valid) begin
      if (cfg_index == CFG_MODE) mode_r <= cfg_data[2:0];
      else if (cfg_index == CFG_COUNT) count_r <= cfg_data[2:0];
      else begin
        for (int i = 0; i < RANGE_SLOTS; i++)
          if ({1'b0, cfg_index} == 4'(i + 2)) range_r[i] <= cfg_data;
      end
    end
  end

  // Decode of the access in flight (raise uses IF).
  logic [15:0] a;
  logic        is_wr;
  logic [7:0]  d;
  logic        ov_act, hit;
  logic [2:0]  slot, nslots;
  logic        in_wram, in_echo, in_restr, in_hi;
  logic [15:0] fa;
  logic [WRAM_AW-1:0] widx;
  logic [16:0] wsum;

  always_comb begin
    a      = (cmd.rmw || func_r == FUNC_RAISE) ? REG_IF : addr_r;
    is_wr  = cmd.rmw || (func_r == FUNC_WRITE);
    d      = cmd.rmw ? (ifv_r | (8'd1 << bit_r)) : wd_r;
    ov_act = boot_r && !mode_r[2];
    nslots = (count_r > 3'(RANGE_SLOTS)) ? 3'(RANGE_SLOTS) : count_r;
    hit    = 1'b0;
    slot   = '0;
    for (int i = RANGE_SLOTS - 1; i >= 0; i--) begin
      if (3'(i) < nslots && a >= range_r[i][31:16] && a <= range_r[i][15:0]) begin
        hit  = 1'b1;
        slot = 3'(i);
      end
    end
    in_wram  = a >= 16'hC000 && a <= 16'hDFFF;
    in_echo  = a >= 16'hE000 && a <= 16'hFDFF;
    in_restr = a >= 16'hFEA0 && a <= 16'hFEFF;
    in_hi    = a >= 16'hFF00;
    fa       = in_echo ? a - 16'h2000 : a;
    if (fa[12]) wsum = 17'({bank_r, 12'h000}) + 17'(fa[11:0]);
    else        wsum = 17'(fa[11:0]);
    widx     = wsum[WRAM_AW-1:0];
  end

  assign hkey = (in_func == FUNC_RAISE) ? REG_IF[7:0] : in_address[7:0];

  logic do_exec;
  assign do_exec = cmd.exec || cmd.rmw;

  always_ff @(posedge clk) begin
    if (do_exec && is_wr && !(a == REG_BOOT_OFF && ov_act) && !hit
        && (in_wram || in_echo))
      wram[widx] <= d;
    wq_r <= wram[widx];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      boot_r   <= 1'b1;
      bank_r   <= 3'd1;
      hvalid_r <= '0;
    end else if (do_exec && is_wr) begin
      if (a == REG_BOOT_OFF && ov_act) boot_r <= 1'b0;
      else if (!hit && !in_wram && !in_echo && !in_restr) begin
        if (a == REG_IF) begin
          hram_r[8'h0F] <= d | 8'hE0; hvalid_r[8'h0F] <= 1'b1;
        end else if (a == REG_SPEED) begin
          hram_r[8'h4D] <= d & 8'h01; hvalid_r[8'h4D] <= 1'b1;
        end else if (a == REG_BANK && mode_r[0]) begin
          bank_r <= (d[2:0] == 3'd0) ? 3'd1 : d[2:0];
        end else if (in_hi) begin
          hram_r[a[7:0]] <= d; hvalid_r[a[7:0]] <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r <= in_func;
      addr_r <= in_address;
      wd_r   <= in_write_data;
      bit_r  <= in_interrupt_bit;
      // Earlier writes have all landed by the time a request is captured.
      hq_r   <= hvalid_r[hkey] ? hram_r[hkey] : hram_reset(hkey);
    end
    if (do_exec) begin
      rdat_r <= '0; fwd_r <= 1'b0; slot_r <= '0; st_r <= ST_OK; wsel_r <= 1'b0;
      if (func_r == FUNC_RAISE && cmd.exec) begin
        // Read half of a raise: keep the IF value, forwarded reads count as 0.
        ifv_r <= (hit && !(ov_act && a < 16'(BOOT_ROM_BYTES))) ? 8'h00 : hq_r;
      end else if (func_r > FUNC_RAISE) begin
        // Undefined function: all fields zero.
      end else if (!is_wr && ov_act && a < 16'(BOOT_ROM_BYTES)) begin
        rdat_r <= BOOT_ROM[a[7:0]];
      end else if (is_wr && a == REG_BOOT_OFF && ov_act) begin
      end else if (hit) begin
        fwd_r <= 1'b1; slot_r <= slot;
      end else if (in_wram || in_echo) begin
        wsel_r <= !is_wr;
      end else if (in_restr) begin
        st_r <= ST_RESTR;
      end else if (!in_hi) begin
        st_r <= ST_UNKNOWN;
      end else if (!is_wr) begin
        if (a == REG_SPEED) rdat_r <= {mode_r[1], 6'h3F, hq_r[0]};
        else if (a == REG_BANK && mode_r[0]) rdat_r <= {5'h1F, bank_r};
        else rdat_r <= hq_r;
      end
    end
  end

  assign read_data      = wsel_r ? wq_r : rdat_r;
  assign forwarded      = fwd_r;
  assign forward_slot   = slot_r;
  assign status         = st_r;
  assign stat.is_raise  = (func_r == FUNC_RAISE);
  assign stat.out_taken = out_tready;
endmodule

// ===== rtl/core/banked_memory_map_decoder_core.sv =====
// ----------------------------------------------------------------------------
// banked_memory_map_decoder_core
// Bus access decoder with boot overlay, forwarding ranges and banked RAM.
// ----------------------------------------------------------------------------
// channel | dir | contents
// in_     | in  | func, address, write_data, interrupt_bit
// out_    | out | read_data, forwarded, forward_slot, status
// cfg_    | in  | register index and 32-bit data
// A read or write passes capture, decode and result states; a raise adds the
// IF write-back state after decode. The high RAM byte is read into a register
// as the request is accepted and work RAM is read through its registered port
// during decode. A new request is accepted in the cycle the result is taken.
// Reset is synchronous; no clearing pass is needed.
// A stalled result holds until out_tready.
`include "assert_macros.svh"
module banked_memory_map_decoder_core import bmmd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,  // func[1:0], address[17:2], write_data[25:18], bit[28:26]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata, // read_data[7:0], forwarded[8], slot[11:9], status[13:12]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  cmd_t  cmd;
  stat_t stat;
  logic [7:0] rd;
  logic fw;
  logic [2:0] sl;
  logic [1:0] st;

  assign cfg_ready = 1'b1;

  bmmd_ctrl u_ctrl (
    .clk, .rst_n, .in_tvalid, .in_tready, .out_tvalid, .stat, .cmd
  );

  bmmd_datapath u_dp (
    .clk, .rst_n, .cmd, .stat, .out_tready,
    .in_func(in_tdata[1:0]), .in_address(in_tdata[17:2]),
    .in_write_data(in_tdata[25:18]), .in_interrupt_bit(in_tdata[28:26]),
    .cfg_valid, .cfg_index, .cfg_data,
    .read_data(rd), .forwarded(fw), .forward_slot(sl), .status(st)
  );

  assign out_tdata = {2'b00, st, sl, fw, rd};

  `ASSERT_IMPL(a_no_fwd_data, clk, rst_n, out_tvalid && fw, rd == 8'h00 && st == ST_OK,
               "forwarded result carries data")
  `ASSERT_NEXT(a_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata),
               "stalled result changed")
  `ASSERT_IMPL(a_excl, clk, rst_n, cmd.load, in_tready,
               "request captured without ready")
endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the banked memory map decoder core: requests are
// predicted by a behavioral copy of the address map, then checked in order.
// ----------------------------------------------------------------------------
module tb;
  import bmmd_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0] data;
    logic       fwd;
    logic [2:0] slot;
    logic [1:0] status;
  } access_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  banked_memory_map_decoder_core dut (.*);

  always #1 clk = ~clk;

  // Predictor state.
  logic [2:0]  mode_q;
  logic [2:0]  count_q;
  logic [31:0] ranges_q [6];
  logic [7:0]  wram_m [WORK_RAM_BYTES];
  bit          wram_set [WORK_RAM_BYTES];
  logic [7:0]  hram_m [256];
  logic        overlay_q;
  logic [2:0]  bank_q;

  access_t expected_q [$];
  int mismatches = 0;
  int checked = 0;
  int stall_pct = 14;
  int idle_cycles = 0;

  function automatic int range_hit(logic [15:0] a);
    int n;
    n = (count_q > RANGE_SLOTS) ? RANGE_SLOTS : count_q;
    for (int i = 0; i < n; i++)
      if (a >= ranges_q[i][31:16] && a <= ranges_q[i][15:0]) return i;
    return -1;
  endfunction

  function automatic int wram_idx(logic [15:0] a);
    if (a < 16'hD000) return a - 16'hC000;
    return (bank_q * 32'h1000 + (a - 16'hD000)) % WORK_RAM_BYTES;
  endfunction

  function automatic logic overlay_on();
    return overlay_q && !mode_q[2];
  endfunction

  function automatic access_t bus_read(logic [15:0] a);
    access_t r;
    int s;
    r = '0;
    s = range_hit(a);
    if (overlay_on() && a < BOOT_ROM_BYTES) r.data = BOOT_ROM[a[7:0]];
    else if (s >= 0) begin
      r.fwd = 1'b1;
      r.slot = s[2:0];
    end else if (a >= 16'hC000 && a <= 16'hDFFF) r.data = wram_m[wram_idx(a)];
    else if (a >= 16'hE000 && a <= 16'hFDFF) r.data = wram_m[wram_idx(a - 16'h2000)];
    else if (a >= 16'hFEA0 && a <= 16'hFEFF) r.status = ST_RESTR;
    else if (a == REG_SPEED) r.data = 8'h7E | hram_m[8'h4D][0] | (mode_q[1] << 7);
    else if (a == REG_BANK && mode_q[0]) r.data = 8'hF8 | bank_q;
    else if (a >= 16'hFF00) r.data = hram_m[a[7:0]];
    else r.status = ST_UNKNOWN;
    return r;
  endfunction

  function automatic access_t bus_write(logic [15:0] a, logic [7:0] d);
    access_t r;
    int s;
    r = '0;
    s = range_hit(a);
    if (a == REG_BOOT_OFF && overlay_on()) overlay_q = 1'b0;
    else if (s >= 0) begin
      r.fwd = 1'b1;
      r.slot = s[2:0];
    end else if (a >= 16'hC000 && a <= 16'hDFFF) begin
      wram_m[wram_idx(a)] = d;
      wram_set[wram_idx(a)] = 1;
    end else if (a >= 16'hE000 && a <= 16'hFDFF) begin
      wram_m[wram_idx(a - 16'h2000)] = d;
      wram_set[wram_idx(a - 16'h2000)] = 1;
    end else if (a >= 16'hFEA0 && a <= 16'hFEFF) r.status = ST_RESTR;
    else if (a == REG_IF) hram_m[8'h0F] = d | 8'hE0;
    else if (a == REG_SPEED) hram_m[8'h4D] = {7'd0, d[0]};
    else if (a == REG_BANK && mode_q[0]) bank_q = (d[2:0] == 0) ? 3'd1 : d[2:0];
    else if (a >= 16'hFF00) hram_m[a[7:0]] = d;
    else r.status = ST_UNKNOWN;
    return r;
  endfunction

  function automatic access_t decode_access(logic [1:0] f, logic [15:0] a,
                                            logic [7:0] d, logic [2:0] b);
    access_t r;
    r = '0;
    if (f == FUNC_READ) r = bus_read(a);
    else if (f == FUNC_WRITE) r = bus_write(a, d);
    else if (f == FUNC_RAISE) begin
      r = bus_read(REG_IF);
      r = bus_write(REG_IF, r.data | (8'd1 << b));
    end
    if (f != FUNC_READ) r.data = '0;
    return r;
  endfunction

  // A read is legal unless it lands on work RAM that was never written.
  function automatic bit read_ok(logic [15:0] a);
    if (overlay_on() && a < BOOT_ROM_BYTES) return 1;
    if (range_hit(a) >= 0) return 1;
    if (a >= 16'hC000 && a <= 16'hDFFF) return wram_set[wram_idx(a)];
    if (a >= 16'hE000 && a <= 16'hFDFF) return wram_set[wram_idx(a - 16'h2000)];
    return 1;
  endfunction

  // Valid stays high after a request is taken so back-to-back requests need
  // only one assignment per edge; gaps and the drain drop it.
  task automatic send_request(logic [1:0] f, logic [15:0] a, logic [7:0] d = 0,
                              logic [2:0] b = 0);
    logic [15:0] addr;
    addr = a;
    if (f == FUNC_READ && !read_ok(addr)) addr = 16'hFF80;
    while ($urandom_range(99) < stall_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {3'd0, b, d, addr, f};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    expected_q.push_back(decode_access(f, addr, d, b));
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
  endtask

  task automatic write_cfg(logic [2:0] idx, logic [31:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
    if (idx == CFG_MODE) mode_q = v[2:0];
    else if (idx == CFG_COUNT) count_q = v[2:0];
    else ranges_q[idx - 2] = v;
  endtask

  always @(posedge clk) begin
    if (rst_n && $urandom_range(99) >= stall_pct) out_tready <= 1'b1;
    else out_tready <= 1'b0;
  end

  always @(posedge clk) begin
    access_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = {out_tdata[7:0], out_tdata[8], out_tdata[11:9], out_tdata[13:12]};
      checked++;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", out_tdata);
      end else begin
        want = expected_q.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result %0d: expected data %h fwd %b slot %0d st %0d, got %h %b %0d %0d",
                     checked, want.data, want.fwd, want.slot, want.status,
                     got.data, got.fwd, got.slot, got.status);
        end
      end
    end
  end

  // Watchdog on cycles without any accepted request, result or configuration write.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 2000) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic test_directed();
    send_request(FUNC_READ, 16'h0000);
    send_request(FUNC_READ, 16'h00FF);
    send_request(FUNC_WRITE, 16'h0010, 8'hAA);
    send_request(FUNC_READ, 16'h0010);
    send_request(FUNC_WRITE, 16'hC000, 8'h5A);
    send_request(FUNC_READ, 16'hE000);
    send_request(FUNC_WRITE, 16'hFDFF, 8'hFF);
    send_request(FUNC_READ, 16'hDDFF);
    send_request(FUNC_READ, 16'hFEA0);
    send_request(FUNC_WRITE, 16'hFEFF, 8'h11);
    send_request(FUNC_READ, 16'hFF4D);
    send_request(FUNC_WRITE, 16'hFF4D, 8'hFF);
    send_request(FUNC_READ, 16'hFF4D);
    send_request(FUNC_WRITE, 16'hFF70, 8'h00);
    send_request(FUNC_READ, 16'hFF70);
    send_request(FUNC_WRITE, 16'hFF0F, 8'h00);
    send_request(FUNC_READ, 16'hFF0F);
    send_request(FUNC_RAISE, 16'h0000, 8'h00, 3'd7);
    send_request(FUNC_READ, 16'hFF0F);
    send_request(FUNC_READ, 16'h8000);
    send_request(FUNC_READ, 16'hFFFF);
    send_request(FUNC_WRITE, 16'hFF50, 8'h01);
    send_request(FUNC_READ, 16'h0000);
    send_request(2'd3, 16'hFFFF, 8'hFF, 3'd7);
    wait_drained();
  endtask

  task automatic test_random(int n);
    logic [15:0] a;
    for (int i = 0; i < n; i++) begin
      stall_pct = (i % 400 < 80) ? 0 : 14;
      case ($urandom_range(9))
        0, 1: a = 16'hC000 + 16'($urandom_range(16'h1FFF));
        2: a = 16'hE000 + 16'($urandom_range(16'h1DFF));
        3: a = 16'hFE80 + 16'($urandom_range(16'h7F));
        4: a = 16'hFF00 + 16'($urandom_range(16'hFF));
        5: a = ($urandom_range(1)) ? REG_BANK : REG_SPEED;
        6: a = ($urandom_range(1)) ? REG_IF : REG_BOOT_OFF;
        7: a = 16'($urandom_range(16'h1FF));
        default: a = 16'($urandom_range(16'hFFFF));
      endcase
      send_request(2'($urandom_range(2)), a, 8'($urandom_range(255)),
                   3'($urandom_range(7)));
    end
    stall_pct = 14;
    wait_drained();
  endtask

  task automatic test_ranges();
    write_cfg(CFG_COUNT, 32'd7);
    write_cfg(3'd2, 32'h0000_00FF);
    write_cfg(3'd3, 32'hC800_C8FF);
    write_cfg(3'd4, 32'hFF00_FF0F);
    write_cfg(3'd5, 32'hD000_C000);
    write_cfg(3'd6, 32'hE000_FFFF);
    write_cfg(3'd7, 32'hFFFF_FFFF);
    send_request(FUNC_RAISE, 16'h0, 8'h0, 3'd2);
    test_random(250);
    write_cfg(CFG_COUNT, 32'd2);
    write_cfg(3'd6, 32'h0000_0000);
    test_random(250);
    write_cfg(CFG_COUNT, 32'd0);
  endtask

  initial begin
    for (int i = 0; i < WORK_RAM_BYTES; i++) begin
      wram_m[i] = '0;
      wram_set[i] = 0;
    end
    for (int i = 0; i < 256; i++)
      hram_m[i] = (i == 8'h0F) ? 8'hE1 : (i <= 8'h7E && i != 8'h4D) ? 8'hFF : 8'h00;
    mode_q = '0;
    count_q = '0;
    foreach (ranges_q[i]) ranges_q[i] = '0;
    overlay_q = 1'b1;
    bank_q = 3'd1;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    write_cfg(CFG_MODE, 32'd7);
    test_random(400);
    write_cfg(CFG_MODE, 32'd1);
    test_ranges();
    write_cfg(CFG_MODE, 32'd0);
    test_random(400);
    write_cfg(CFG_MODE, 32'd5);
    test_random(400);
    $display("Checked %0d results over boot overlay, ranges, banked and echo RAM,", checked);
    $display("I/O registers and interrupt raises in several modes.");
    if (mismatches == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end
endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/bmmd_pkg.sv
rtl/core/bmmd_ctrl.sv
rtl/core/bmmd_datapath.sv
rtl/core/banked_memory_map_decoder_core.sv
tb/tb.sv
